// File: hdl/dmc_pkg.sv
// Package with types, constants and helpers for the maze carver.
`timescale 1ns / 1ps
package dmc_pkg;

  localparam int unsigned DefRows = 8;
  localparam int unsigned DefCols = 32;
  localparam int unsigned StackMax = 256;

  localparam logic [1:0] KIND_EDIT     = 2'd0;
  localparam logic [1:0] KIND_SKIP     = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;
  localparam logic [1:0] KIND_STARTED  = 2'd3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  start_node;
    logic [15:0] random_value;
  } dmc_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  word_address;
    logic [31:0] and_mask;
    logic        last;
  } dmc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PUSH,
    ST_POP_RD,
    ST_POP_CHK,
    ST_MOD,
    ST_PICK,
    ST_VIS,
    ST_EMIT,
    ST_REPLY
  } dmc_state_t;

  function automatic logic [31:0] vert_mask(input logic [1:0] sel);
    case (sel)
      2'd0:    vert_mask = 32'hFFFFFF00;
      2'd1:    vert_mask = 32'hFFFF00FF;
      2'd2:    vert_mask = 32'hFF00FFFF;
      default: vert_mask = 32'h00FFFFFF;
    endcase
  endfunction

  function automatic logic [31:0] horz_mask(input logic [1:0] sel);
    case (sel)
      2'd0:    horz_mask = 32'hFFFFFFE1;
      2'd1:    horz_mask = 32'hFFFFE1FF;
      2'd2:    horz_mask = 32'hFFE1FFFF;
      default: horz_mask = 32'hE1FFFFFF;
    endcase
  endfunction

endpackage

// File: hdl/dfs_maze_carver.sv
// Randomized depth-first maze carver with an explicit frame stack in memory.
// A start clears the visited map, then pushes the start cell and sends a started beat.
// A step pops spent frames and sends a finished beat when the stack runs empty;
// otherwise the shift-subtract remainder unit picks a neighbour; it sends a skip
// beat, or edits and a push. Output stalls add cycles; in_stall is high until done.
// Reset (rst, synchronous) empties the stack; the visited map is cleared by each start.
`timescale 1ns / 1ps
module dfs_maze_carver
  import dmc_pkg::*;
#(
  parameter int unsigned ROWS = DefRows,
  parameter int unsigned COLS = DefCols
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dmc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output dmc_out_t out_data
);

  localparam int unsigned NCells = ROWS * COLS;
  // Reciprocals scaled by 2^16; exact quotients for any 8-bit dividend.
  localparam int unsigned ColRecip  = (65536 + COLS - 1) / COLS;
  localparam int unsigned CellRecip = (65536 + NCells - 1) / NCells;

  function automatic logic [7:0] row_of(input logic [7:0] c);
    logic [23:0] p;
    p = 24'(c) * 24'(ColRecip);
    return p[23:16];
  endfunction

  function automatic logic [7:0] col_of(input logic [7:0] c);
    return 8'(c - 8'(row_of(c) * 8'(COLS)));
  endfunction

  dmc_state_t state, state_next;

  logic        visited [StackMax];
  logic [7:0]  fr_cell [StackMax];
  logic [31:0] fr_nb   [StackMax];
  logic [2:0]  fr_rem  [StackMax];

  logic [8:0]  depth;
  logic [7:0]  clr_idx;
  logic [7:0]  node;        // cell to push
  logic [15:0] rnd;
  logic [15:0] rem_acc;     // running remainder
  logic [4:0]  bit_cnt;
  logic [2:0]  rem;
  logic [7:0]  cur;
  logic [31:0] list;
  logic [7:0]  pick;
  logic [7:0]  pick_sel;
  logic        vis_rd;
  logic [2:0]  rd_rem;
  logic [7:0]  rd_cell;
  logic [31:0] rd_nb;
  logic [1:0]  edit_cnt;
  logic        vertical;
  logic [8:0]  base;
  logic [1:0]  sel;
  logic [1:0]  reply_kind;
  logic        out_full;
  logic        beat_load;
  logic [31:0] swapped;

  wire [7:0] top = 8'(depth - 9'd1);

  // Neighbour list of the cell being pushed.
  logic [31:0] nb_list;
  logic [2:0]  nb_n;
  always_comb begin
    logic [7:0] col, row;
    col = col_of(node);
    row = row_of(node);
    nb_list = '0;
    nb_n = '0;
    if (col > 0) begin
      nb_list[8*nb_n[1:0] +: 8] = 8'(node - 8'd1);
      nb_n = nb_n + 3'd1;
    end
    if (32'(col) < COLS - 1) begin
      nb_list[8*nb_n[1:0] +: 8] = 8'(node + 8'd1);
      nb_n = nb_n + 3'd1;
    end
    if (row > 0) begin
      nb_list[8*nb_n[1:0] +: 8] = 8'(node - 8'(COLS));
      nb_n = nb_n + 3'd1;
    end
    if (32'(row) < ROWS - 1) begin
      nb_list[8*nb_n[1:0] +: 8] = 8'(node + 8'(COLS));
      nb_n = nb_n + 3'd1;
    end
  end

  // Start cell reduced into the grid.
  logic [7:0] start_red;
  always_comb begin
    logic [23:0] prod;
    prod = 24'(in_data.start_node) * 24'(CellRecip);
    start_red = 8'(16'(in_data.start_node) - 16'(prod[23:16]) * 16'(NCells));
  end

  // Restoring remainder step of the remainder unit.
  logic [16:0] trial;
  assign trial = {rem_acc, rnd[15]} - 17'(rem);

  assign pick_sel = list[8*rem_acc[1:0] +: 8];

  // Link geometry.
  logic [7:0] src, dst, src_col;
  always_comb begin
    src = (cur < pick) ? cur : pick;
    dst = (cur < pick) ? pick : cur;
    src_col = col_of(src);
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.operation == OP_START) state_next = ST_CLEAR;
          else state_next = ST_POP_RD;
        end
      end
      ST_CLEAR:   if (32'(clr_idx) == StackMax - 1) state_next = ST_PUSH;
      ST_PUSH:    if (!out_full) state_next = ST_IDLE;
      ST_POP_RD: begin
        if (depth == 9'd0) state_next = ST_REPLY;
        else state_next = ST_POP_CHK;
      end
      ST_POP_CHK: begin
        if (rd_rem == 3'd0) state_next = ST_POP_RD;
        else state_next = ST_MOD;
      end
      ST_MOD:  if (bit_cnt == 5'd16) state_next = ST_PICK;
      ST_PICK: state_next = ST_VIS;
      ST_VIS: begin
        if (vis_rd) state_next = ST_REPLY;
        else state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_full && ((vertical && edit_cnt == 2'd3) || (!vertical && edit_cnt == 2'd1)))
          state_next = ST_PUSH;
      end
      ST_REPLY: if (!out_full) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_full = out_valid && out_stall;

  assign beat_load = !out_full && ((state == ST_EMIT) || (state == ST_REPLY) ||
                                   (state == ST_PUSH && reply_kind == KIND_STARTED));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      depth <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= beat_load || out_full;
      case (state)
        ST_IDLE: begin
          rnd <= in_data.random_value;
          clr_idx <= '0;
          node <= start_red;
          reply_kind <= KIND_STARTED;
          if (in_valid && in_data.operation == OP_START) depth <= '0;
        end
        ST_CLEAR: clr_idx <= clr_idx + 8'd1;
        ST_POP_RD: reply_kind <= KIND_FINISHED;
        ST_POP_CHK: begin
          if (rd_rem == 3'd0) depth <= depth - 9'd1;
          rem <= (rd_rem > 3'd4) ? 3'd4 : rd_rem;
          cur <= rd_cell;
          list <= rd_nb;
          rem_acc <= '0;
          bit_cnt <= '0;
        end
        ST_MOD: begin
          if (bit_cnt != 5'd16) begin
            rnd <= {rnd[14:0], 1'b0};
            if (!trial[16]) rem_acc <= trial[15:0];
            else rem_acc <= {rem_acc[14:0], rnd[15]};
            bit_cnt <= bit_cnt + 5'd1;
          end
        end
        ST_PICK: begin
          pick <= pick_sel;
          node <= pick_sel;
          reply_kind <= KIND_SKIP;
          edit_cnt <= '0;
        end
        ST_VIS: begin
          vertical <= (dst - src) > 8'd1;
          base <= 9'({row_of(dst), 6'd0}) + 9'(src_col[7:2]);
          sel <= src_col[1:0];
        end
        ST_EMIT: begin
          if (!out_full) begin
            out_data.kind <= KIND_EDIT;
            out_data.and_mask <= vertical ? vert_mask(sel) : horz_mask(sel);
            out_data.word_address <= vertical ? 9'(base + 9'(({7'd0, edit_cnt} + 9'd3) * 9'd8))
                                              : 9'(base + 9'({7'd0, edit_cnt} * 9'd8));
            out_data.last <= vertical ? (edit_cnt == 2'd3) : (edit_cnt == 2'd1);
            edit_cnt <= edit_cnt + 2'd1;
          end
        end
        ST_PUSH: begin
          if (!out_full) begin
            if (32'(depth) < StackMax) depth <= depth + 9'd1;
            if (reply_kind == KIND_STARTED)
              out_data <= '{kind: KIND_STARTED, word_address: '0, and_mask: '1, last: 1'b1};
          end
        end
        ST_REPLY: begin
          if (!out_full)
            out_data <= '{kind: reply_kind, word_address: '0, and_mask: '1, last: 1'b1};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [1:0] li;
    logic [1:0] pi;
    pi = rem_acc[1:0];
    li = 2'(rem - 3'd1);
    swapped = list;
    swapped[8*pi +: 8] = list[8*li +: 8];
    swapped[8*li +: 8] = list[8*pi +: 8];
  end

  // Stack and visited memories, one access per port each cycle.
  always_ff @(posedge clk) begin
    rd_rem  <= fr_rem[top];
    rd_cell <= fr_cell[top];
    rd_nb   <= fr_nb[top];
    vis_rd  <= visited[pick_sel];
    if (state == ST_CLEAR) visited[clr_idx] <= 1'b0;
    else if (state == ST_PUSH && !out_full) visited[node] <= 1'b1;
    if (state == ST_PUSH && !out_full && 32'(depth) < StackMax) begin
      fr_cell[depth[7:0]] <= node;
      fr_nb[depth[7:0]]   <= nb_list;
      fr_rem[depth[7:0]]  <= nb_n;
    end else if (state == ST_PICK) begin
      fr_rem[top] <= rem - 3'd1;
      fr_nb[top]  <= swapped;
    end
  end

endmodule
